// ----- design/rtt_pkg.sv -----
// package for the repeating timer table
// types, codes and widths shared by the controller, datapath and top level
`timescale 1ns / 1ps

package rtt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int SLOT_LIMIT      = 16;

    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 31;
    localparam int REPEAT_W = 32;
    localparam int SLOT_W   = 4;
    localparam int MODE_W   = 2;
    localparam int KIND_W   = 2;
    localparam int ENTRY_W  = TIME_W + DELAY_W + REPEAT_W;

    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

    localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADDED     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FULL      = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [TIME_W-1:0]          now_ms;
        logic [DELAY_W-1:0]         delay_ms;
        logic signed [REPEAT_W-1:0] repeat_count;
        logic [SLOT_W-1:0]          slot_id;
    } t_request;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_result;

    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_run;
        logic flush;
        logic do_add;
        logic do_cancel;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_stat;

endpackage

// ----- design/rtt_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/rtt_ctrl.sv -----
// controller state machine for the timer table
// uses rtt_pkg command and status types; drives the datapath
`timescale 1ns / 1ps

module rtt_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [rtt_pkg::MODE_W-1:0] i_mode,
    input  rtt_pkg::t_dp_stat         i_stat,
    output rtt_pkg::t_dp_cmd          o_cmd,
    output logic                      busy
);
    import rtt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ADD    = 2'd1;
    localparam logic [1:0] ST_CANCEL = 2'd2;
    localparam logic [1:0] ST_SCAN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.capture = accept;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_TICK: begin
                            n_state         = ST_SCAN;
                            o_cmd.scan_init = 1'b1;
                        end
                        MODE_ADD:    n_state = ST_ADD;
                        MODE_CANCEL: n_state = ST_CANCEL;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                o_cmd.do_add = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_CANCEL: begin
                o_cmd.do_cancel = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/rtt_datapath.sv -----
// datapath of the timer table: slot valid bits, slot ram, scan pipeline, result register
// uses rtt_pkg types and rtt_ram; commanded by rtt_ctrl
`timescale 1ns / 1ps

module rtt_datapath #(
    parameter int SLOTS = rtt_pkg::SLOT_LIMIT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtt_pkg::t_request i_req,
    input  rtt_pkg::t_dp_cmd  i_cmd,
    output rtt_pkg::t_dp_stat o_stat,
    output logic              o_strobe,
    output rtt_pkg::t_result  o_res
);
    import rtt_pkg::*;

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    t_request           r_req;
    logic [SLOTS-1:0]   r_valid;
    logic [SLOTS-1:0]   n_valid;
    logic [CNT_W-1:0]   r_rd_idx;
    logic [CNT_W-1:0]   n_rd_idx;
    logic               r_ev_vld;
    logic               n_ev_vld;
    logic [AW-1:0]      r_ev_idx;
    logic [AW-1:0]      n_ev_idx;
    logic               r_pend;
    logic               n_pend;
    logic [AW-1:0]      r_pend_slot;
    logic [AW-1:0]      n_pend_slot;
    logic               r_out_vld;
    logic               n_out_vld;
    t_result            r_out;
    t_result            n_out;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [TIME_W-1:0]   rd_start;
    logic [DELAY_W-1:0]  rd_delay;
    logic [REPEAT_W-1:0] rd_repeat;
    logic [TIME_W-1:0]   elapsed;
    logic                due;
    logic [REPEAT_W-1:0] next_repeat;

    logic [SLOTS-1:0]   free_onehot;
    logic               any_free;
    logic [AW-1:0]      free_idx;
    logic               cancel_hit;

    assign {rd_start, rd_delay, rd_repeat} = ram_rdata;
    assign elapsed = r_req.now_ms - rd_start;
    assign due     = elapsed >= {1'b0, rd_delay};
    // positive counts go down, negative ones repeat forever
    assign next_repeat = rd_repeat[REPEAT_W-1] ? rd_repeat : rd_repeat - 1'b1;

    // lowest clear valid bit
    assign free_onehot = ~r_valid & (r_valid + 1'b1);
    assign any_free    = |(~r_valid);
    always_comb begin
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (free_onehot[i]) begin
                free_idx = free_idx | AW'(i);
            end
        end
    end

    assign cancel_hit = (32'(r_req.slot_id) < SLOTS);

    assign o_stat.scan_done = (r_rd_idx == CNT_W'(SLOTS)) && !r_ev_vld;

    always_comb begin
        n_valid     = r_valid;
        n_rd_idx    = r_rd_idx;
        n_ev_vld    = r_ev_vld;
        n_ev_idx    = r_ev_idx;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_out_vld   = 1'b0;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_ev_idx;
        ram_wdata   = {r_req.now_ms, rd_delay, next_repeat};

        if (i_cmd.scan_init) begin
            n_rd_idx = '0;
            n_ev_vld = 1'b0;
            n_pend   = 1'b0;
        end

        if (i_cmd.scan_run) begin
            if (r_rd_idx != CNT_W'(SLOTS)) begin
                n_ev_vld = 1'b1;
                n_ev_idx = r_rd_idx[AW-1:0];
                n_rd_idx = r_rd_idx + 1'b1;
            end else begin
                n_ev_vld = 1'b0;
            end
        end

        // evaluate the entry read in the previous cycle
        if (r_ev_vld && r_valid[r_ev_idx] && due) begin
            // one fired result is held back so the final one can carry last
            if (r_pend) begin
                n_out_vld  = 1'b1;
                n_out.kind = KIND_FIRED;
                n_out.slot = SLOT_W'(r_pend_slot);
                n_out.last = 1'b0;
            end
            n_pend      = 1'b1;
            n_pend_slot = r_ev_idx;
            if (rd_repeat == '0) begin
                n_valid[r_ev_idx] = 1'b0;
            end else begin
                ram_we = 1'b1;
            end
        end

        if (i_cmd.flush && r_pend) begin
            n_out_vld  = 1'b1;
            n_out.kind = KIND_FIRED;
            n_out.slot = SLOT_W'(r_pend_slot);
            n_out.last = 1'b1;
            n_pend     = 1'b0;
        end

        if (i_cmd.do_add) begin
            n_out_vld  = 1'b1;
            n_out.last = 1'b1;
            if (any_free) begin
                n_valid[free_idx] = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = free_idx;
                ram_wdata  = {r_req.now_ms, r_req.delay_ms, r_req.repeat_count};
                n_out.kind = KIND_ADDED;
                n_out.slot = SLOT_W'(free_idx);
            end else begin
                n_out.kind = KIND_FULL;
                n_out.slot = '0;
            end
        end

        if (i_cmd.do_cancel) begin
            if (cancel_hit) begin
                n_valid[r_req.slot_id[AW-1:0]] = 1'b0;
            end
            n_out_vld  = 1'b1;
            n_out.kind = KIND_CANCELLED;
            n_out.slot = r_req.slot_id;
            n_out.last = 1'b1;
        end
    end

    rtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_idx  <= '0;
            r_ev_vld  <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_rd_idx  <= n_rd_idx;
            r_ev_vld  <= n_ev_vld;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        r_ev_idx    <= n_ev_idx;
        r_pend_slot <= n_pend_slot;
        r_out       <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_res    = r_out;

endmodule

// ----- design/repeating_timer_table.sv -----
// top level of the repeating timer table
// instantiates rtt_ctrl and rtt_datapath; types from rtt_pkg
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. An add or a cancel
// keeps busy high while the controller sits in its ADD or CANCEL state and
// gives one registered result in the cycle in which busy falls; mode 3 is
// taken and does nothing. A tick keeps busy high until every slot has been
// read from the slot ram, one entry a cycle through its single read port, and
// evaluated, and gives one fired result per due slot, in ascending slot order,
// with last set on the final one; a tick with nothing due gives no result.
// Each result sits on o_res for exactly one cycle with o_strobe high, and the
// receiver cannot hold it off, so it must take every strobe. Slots used are
// the smaller of TIMER_SLOTS and sixteen.
module repeating_timer_table #(
    parameter int TIMER_SLOTS = rtt_pkg::TIMER_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  rtt_pkg::t_request i_req,
    output logic              busy,
    output logic              o_strobe,
    output rtt_pkg::t_result  o_res
);
    import rtt_pkg::*;

    localparam int USABLE = (TIMER_SLOTS < SLOT_LIMIT) ? TIMER_SLOTS : SLOT_LIMIT;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rtt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_req.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    rtt_datapath #(
        .SLOTS (USABLE)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the repeating timer table
// drives requests through start/busy and checks every strobed result; needs rtt_pkg
`timescale 1ns / 1ps

module testbench;
    import rtt_pkg::*;

    localparam int USABLE = (TIMER_SLOTS_DEF < SLOT_LIMIT) ? TIMER_SLOTS_DEF : SLOT_LIMIT;
    localparam int RANDOM_ITEMS = 410;
    localparam int LIMIT_NS = 5_000_000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_request i_req   = '0;
    logic     busy;
    logic     o_strobe;
    t_result  o_res;

    repeating_timer_table i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // own copy of the slot table
    logic                       tmr_valid [USABLE];
    logic [TIME_W-1:0]          tmr_start [USABLE];
    logic [DELAY_W-1:0]         tmr_delay [USABLE];
    logic signed [REPEAT_W-1:0] tmr_left  [USABLE];

    t_result expected_results [$];

    int errors    = 0;
    int n_ticks   = 0;
    int n_adds    = 0;
    int n_cancels = 0;
    int n_unused  = 0;
    int n_results = 0;
    int n_fired   = 0;
    int n_full    = 0;
    bit idle_en   = 1'b1;
    logic [TIME_W-1:0] cur_ms = '0;

    task automatic update_timers(input t_request r);
        logic [USABLE-1:0] due;
        logic [TIME_W-1:0] elapsed;
        int last_due;
        int free_slot;
        t_result res;
        case (r.mode)
            MODE_TICK: begin
                due = '0;
                last_due = -1;
                for (int i = 0; i < USABLE; i++) begin
                    elapsed = r.now_ms - tmr_start[i];
                    if (tmr_valid[i] && elapsed >= {1'b0, tmr_delay[i]}) begin
                        due[i] = 1'b1;
                        last_due = i;
                    end
                end
                for (int i = 0; i < USABLE; i++) begin
                    if (due[i]) begin
                        res.kind = KIND_FIRED;
                        res.slot = SLOT_W'(i);
                        res.last = (i == last_due);
                        expected_results.push_back(res);
                        if (tmr_left[i] == 0) begin
                            tmr_valid[i] = 1'b0;
                        end else begin
                            // negative counts repeat forever
                            if (!tmr_left[i][REPEAT_W-1])
                                tmr_left[i] = tmr_left[i] - 1;
                            tmr_start[i] = r.now_ms;
                        end
                    end
                end
            end
            MODE_ADD: begin
                free_slot = -1;
                for (int i = 0; i < USABLE; i++)
                    if (!tmr_valid[i] && free_slot < 0)
                        free_slot = i;
                res.last = 1'b1;
                if (free_slot < 0) begin
                    res.kind = KIND_FULL;
                    res.slot = '0;
                end else begin
                    tmr_valid[free_slot] = 1'b1;
                    tmr_start[free_slot] = r.now_ms;
                    tmr_delay[free_slot] = r.delay_ms;
                    tmr_left[free_slot]  = r.repeat_count;
                    res.kind = KIND_ADDED;
                    res.slot = SLOT_W'(free_slot);
                end
                expected_results.push_back(res);
            end
            MODE_CANCEL: begin
                if (r.slot_id < USABLE)
                    tmr_valid[r.slot_id] = 1'b0;
                res.kind = KIND_CANCELLED;
                res.slot = r.slot_id;
                res.last = 1'b1;
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    function automatic t_request make_req(input logic [MODE_W-1:0] mode,
                                          input logic [TIME_W-1:0] now,
                                          input logic [DELAY_W-1:0] dly,
                                          input logic [REPEAT_W-1:0] rep,
                                          input logic [SLOT_W-1:0] sid);
        t_request r;
        r.mode         = mode;
        r.now_ms       = now;
        r.delay_ms     = dly;
        r.repeat_count = rep;
        r.slot_id      = sid;
        return r;
    endfunction

    // leaves start high after acceptance so back-to-back requests need no extra edge
    task automatic send_request(input t_request r);
        if (idle_en && $urandom_range(99) < 22) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        update_timers(r);
        case (r.mode)
            MODE_TICK:   n_ticks++;
            MODE_ADD:    n_adds++;
            MODE_CANCEL: n_cancels++;
            default:     n_unused++;
        endcase
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0 || busy);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind %0d slot %0d last %0d",
                         $time, o_res.kind, o_res.slot, o_res.last);
            end else begin
                want = expected_results.pop_front();
                n_results++;
                if (o_res.kind === KIND_FIRED) n_fired++;
                if (o_res.kind === KIND_FULL) n_full++;
                if (o_res.kind !== want.kind) begin
                    errors++;
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, o_res.kind);
                end
                if (o_res.slot !== want.slot) begin
                    errors++;
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, o_res.slot);
                end
                if (o_res.last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %0d actual %0d", $time, want.last, o_res.last);
                end
            end
        end
    end

    task automatic test_empty_and_unused();
        send_request(make_req(MODE_TICK, '0, '0, '0, '0));
        send_request(make_req(MODE_UNUSED, '1, '1, '1, '1));
    endtask

    task automatic test_single_shot();
        send_request(make_req(MODE_ADD, '0, '0, '0, '0));
        send_request(make_req(MODE_TICK, '0, '0, '0, '0));
        // slot was freed by the firing, so nothing is due now
        send_request(make_req(MODE_TICK, 32'd5, '0, '0, '0));
    endtask

    task automatic test_wrap_forever();
        send_request(make_req(MODE_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, '0));
        // elapsed wraps past zero: one short of the delay, then exactly on it
        send_request(make_req(MODE_TICK, 32'h7FFF_FFFD, '0, '0, '0));
        send_request(make_req(MODE_TICK, 32'h7FFF_FFFE, '0, '0, '0));
        send_request(make_req(MODE_CANCEL, '0, '0, '0, '0));
    endtask

    task automatic test_full_table();
        logic [REPEAT_W-1:0] rep;
        for (int i = 0; i < USABLE; i++) begin
            case (i)
                0:       rep = '0;
                1:       rep = 32'h7FFF_FFFF;
                2:       rep = 32'h8000_0000;
                3:       rep = 32'hFFFF_FFFF;
                default: rep = REPEAT_W'(i % 3);
            endcase
            send_request(make_req(MODE_ADD, 32'd1000, DELAY_W'(i * 5), rep, '0));
        end
        send_request(make_req(MODE_ADD, 32'd1000, '0, '0, '0));
        // every slot due at once
        send_request(make_req(MODE_TICK, 32'd1100, '0, '0, '0));
        send_request(make_req(MODE_CANCEL, 32'd1100, '0, '0, 4'd0));
        send_request(make_req(MODE_CANCEL, 32'd1100, '0, '0, 4'd1));
        wait_all_results();
        cur_ms = 32'd1100;
    endtask

    task automatic test_random_traffic();
        t_request r;
        int pick;
        int sel;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_en = !(n >= 150 && n < 260);
            if (n % 60 == 59)
                wait_all_results();
            r.delay_ms     = DELAY_W'($urandom);
            r.repeat_count = $urandom;
            r.slot_id      = SLOT_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 45) begin
                r.mode = MODE_TICK;
                if ($urandom_range(99) < 4)
                    cur_ms = $urandom;
                else
                    cur_ms = cur_ms + $urandom_range(0, 30);
            end else if (pick < 75) begin
                r.mode = MODE_ADD;
                sel = $urandom_range(99);
                if (sel < 70)      r.delay_ms = DELAY_W'($urandom_range(0, 40));
                else if (sel < 90) r.delay_ms = DELAY_W'($urandom_range(0, 400));
                else if (sel < 97) r.delay_ms = DELAY_W'($urandom);
                else               r.delay_ms = 31'h7FFF_FFFF;
                sel = $urandom_range(99);
                if (sel < 50)      r.repeat_count = $urandom_range(0, 4);
                else if (sel < 70) r.repeat_count = -$signed(REPEAT_W'($urandom_range(1, 3)));
                else if (sel < 90) r.repeat_count = '0;
            end else if (pick < 95) begin
                r.mode = MODE_CANCEL;
                r.slot_id = SLOT_W'($urandom_range(USABLE - 1));
            end else begin
                r.mode = MODE_UNUSED;
            end
            r.now_ms = cur_ms;
            send_request(r);
        end
        idle_en = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < USABLE; i++) begin
            tmr_valid[i] = 1'b0;
            tmr_start[i] = '0;
            tmr_delay[i] = '0;
            tmr_left[i]  = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_unused();
        test_single_shot();
        test_wrap_forever();
        test_full_table();
        test_random_traffic();

        wait_all_results();
        repeat (40) @(posedge i_clk);

        $display("requests: %0d ticks, %0d adds, %0d cancels, %0d unused mode",
                 n_ticks, n_adds, n_cancels, n_unused);
        $display("results checked: %0d, of which %0d firings and %0d table-full reports",
                 n_results, n_fired, n_full);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rtt_pkg.sv
design/rtt_ram.sv
design/rtt_ctrl.sv
design/rtt_datapath.sv
design/repeating_timer_table.sv
verif/testbench.sv
